/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int STAT_W   = 2;

    localparam logic [PAY_W-1:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    typedef enum logic {
        KIND_INSERT  = 1'b0,
        KIND_EXTRACT = 1'b1
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic                    insert;
        logic                    extract;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_cell_ctrl;

endpackage

/* rtl/spq_in_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel carrying one insert or extract request.
// ----------------------------------------------------------------------------
interface spq_in_if;

    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic signed [spq_pkg::KEY_W-1:0]        priority_key;
    logic [spq_pkg::PAY_W-1:0]               payload;

    modport source (output valid, output kind, output priority_key, output payload,
                    input ready);
    modport sink   (input valid, input kind, input priority_key, input payload,
                    output ready);

endinterface

/* rtl/spq_out_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel carrying one status and payload per request.
// ----------------------------------------------------------------------------
interface spq_out_if;

    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STAT_W-1:0]   status;
    logic [spq_pkg::PAY_W-1:0]    out_payload;

    modport source (output valid, output status, output out_payload, input ready);
    modport sink   (input valid, input status, input out_payload, output ready);

endinterface

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts toward the tail on insert and toward the head on
// extract, taking the broadcast entry where it belongs in key order.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                               i_clk,
    input  spq_pkg::t_cell_ctrl                i_ctrl,
    input  logic                               i_occupied,
    input  logic                               i_prev_gt,
    input  logic signed [spq_pkg::KEY_W-1:0]   i_prev_key,
    input  logic [spq_pkg::PAY_W-1:0]          i_prev_payload,
    input  logic signed [spq_pkg::KEY_W-1:0]   i_next_key,
    input  logic [spq_pkg::PAY_W-1:0]          i_next_payload,
    output logic                               o_gt,
    output logic signed [spq_pkg::KEY_W-1:0]   o_key,
    output logic [spq_pkg::PAY_W-1:0]          o_payload
);

    logic signed [spq_pkg::KEY_W-1:0] r_key;
    logic [spq_pkg::PAY_W-1:0]        r_payload;

    // An empty cell ranks after every key, so the new entry goes behind equals.
    assign o_gt      = !i_occupied || (r_key > i_ctrl.key);
    assign o_key     = r_key;
    assign o_payload = r_payload;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.extract) begin
            r_key     <= i_next_key;
            r_payload <= i_next_payload;
        end else if (i_ctrl.insert && o_gt) begin
            if (i_prev_gt) begin
                r_key     <= i_prev_key;
                r_payload <= i_prev_payload;
            end else begin
                r_key     <= i_ctrl.key;
                r_payload <= i_ctrl.payload;
            end
        end
    end

endmodule

/* rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of key/payload entries kept in ascending signed key order in
// a row of cells; extract returns the payload with the smallest key.
//
// Usage: requests arrive on i_in (kind 0 inserts priority_key and payload,
// kind 1 extracts the head entry). Every request produces exactly one
// transaction on o_out with a status (ok, full, empty) and a payload, which
// is zero for inserts and negative infinity bits for an empty extract.
// A request is accepted into the execute state and runs once the response
// register is free or being read; then all cells shift or take the new entry
// at once and the response is registered. No new request is taken before that.
// The response register frees the execute step: a new request
// is accepted while a response still waits. If the receiver stalls and the
// response register is still occupied, the captured request waits in the
// execute state and i_in.ready stays low. Synchronous reset empties the
// queue and clears the handshake state; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_in_if.sink        i_in,
    spq_out_if.source     o_out
);

    localparam int N = spq_pkg::CAPACITY;

    spq_pkg::t_state                  r_state, n_state;
    logic [spq_pkg::CNT_W-1:0]        r_count, n_count;
    logic                             r_kind;
    logic signed [spq_pkg::KEY_W-1:0] r_key;
    logic [spq_pkg::PAY_W-1:0]        r_payload;
    logic                             r_out_valid, n_out_valid;
    logic [spq_pkg::STAT_W-1:0]       r_status, n_status;
    logic [spq_pkg::PAY_W-1:0]        r_out_payload, n_out_payload;
    logic                             w_exec;
    logic                             w_full;
    logic                             w_empty;
    spq_pkg::t_cell_ctrl              w_ctrl;

    logic                             w_gt      [N];
    logic signed [spq_pkg::KEY_W-1:0] w_key     [N];
    logic [spq_pkg::PAY_W-1:0]        w_pay     [N];

    assign i_in.ready        = (r_state == spq_pkg::S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.out_payload = r_out_payload;

    assign w_full  = (r_count == spq_pkg::CNT_W'(N));
    assign w_empty = (r_count == '0);
    assign w_exec  = (r_state == spq_pkg::S_EXEC) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_ctrl.insert  = w_exec && (r_kind == spq_pkg::KIND_INSERT) && !w_full;
        w_ctrl.extract = w_exec && (r_kind == spq_pkg::KIND_EXTRACT) && !w_empty;
        w_ctrl.key     = r_key;
        w_ctrl.payload = r_payload;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic                             w_prev_gt;
            logic signed [spq_pkg::KEY_W-1:0] w_prev_key;
            logic [spq_pkg::PAY_W-1:0]        w_prev_pay;
            logic signed [spq_pkg::KEY_W-1:0] w_next_key;
            logic [spq_pkg::PAY_W-1:0]        w_next_pay;

            if (g == 0) begin : g_head
                assign w_prev_gt  = 1'b0;
                assign w_prev_key = w_key[g];
                assign w_prev_pay = w_pay[g];
            end else begin : g_body
                assign w_prev_gt  = w_gt[g-1];
                assign w_prev_key = w_key[g-1];
                assign w_prev_pay = w_pay[g-1];
            end

            if (g == N - 1) begin : g_tail
                assign w_next_key = w_key[g];
                assign w_next_pay = w_pay[g];
            end else begin : g_inner
                assign w_next_key = w_key[g+1];
                assign w_next_pay = w_pay[g+1];
            end

            spq_cell u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl),
                .i_occupied     (spq_pkg::CNT_W'(g) < r_count),
                .i_prev_gt      (w_prev_gt),
                .i_prev_key     (w_prev_key),
                .i_prev_payload (w_prev_pay),
                .i_next_key     (w_next_key),
                .i_next_payload (w_next_pay),
                .o_gt           (w_gt[g]),
                .o_key          (w_key[g]),
                .o_payload      (w_pay[g])
            );
        end
    endgenerate

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_out_payload = r_out_payload;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (w_exec) begin
                    n_state     = spq_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    if (r_kind == spq_pkg::KIND_INSERT) begin
                        n_out_payload = '0;
                        if (w_full) begin
                            n_status = spq_pkg::STATUS_FULL;
                        end else begin
                            n_status = spq_pkg::STATUS_OK;
                            n_count  = r_count + spq_pkg::CNT_W'(1);
                        end
                    end else begin
                        if (w_empty) begin
                            n_status      = spq_pkg::STATUS_EMPTY;
                            n_out_payload = spq_pkg::NEG_INF_BITS;
                        end else begin
                            n_status      = spq_pkg::STATUS_OK;
                            n_out_payload = w_pay[0];
                            n_count       = r_count - spq_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_out_payload <= n_out_payload;
        if (i_in.valid && i_in.ready) begin
            r_kind    <= i_in.kind;
            r_key     <= i_in.priority_key;
            r_payload <= i_in.payload;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(N))
        else $error("Entry count exceeds capacity.");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == spq_pkg::S_EXEC))
        else $error("Accepted transaction did not enter execution.");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert |=> (r_count == $past(r_count) + spq_pkg::CNT_W'(1)))
        else $error("Insert did not grow the queue by one entry.");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.extract |=> (r_count == $past(r_count) - spq_pkg::CNT_W'(1)))
        else $error("Extract did not shrink the queue by one entry.");

    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == spq_pkg::STATUS_EMPTY))
            |-> (o_out.out_payload == spq_pkg::NEG_INF_BITS))
        else $error("Empty response carries a wrong payload.");

endmodule
